### rtl/core/pcf_pkg.sv
// Shared types, codes and CRC step function for the PNG chunk framer.
// No dependencies; every other file of the block imports this package.
package pcf_pkg;

   localparam logic       KIND_START   = 1'b0;
   localparam logic       KIND_DATA    = 1'b1;
   localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

   // Byte slots of one queued command, as walked by the back end.
   localparam int unsigned STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_LEN_FIRST  = 4'd0;
   localparam logic [STEP_W-1:0] STEP_TYPE_FIRST = 4'd4;
   localparam logic [STEP_W-1:0] STEP_BYTE_LAST  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_CRC_LAST   = 4'd11;

   typedef struct packed {
      logic        kind;
      logic [31:0] chunk_type;
      logic [30:0] chunk_length;
      logic [7:0]  data_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       chunk_end;
   } rsp_item_type;

   // Classified work for the back end. For a payload byte, the byte rides
   // in word[7:0]; close says the CRC follows this command.
   typedef struct packed {
      logic        is_data;
      logic        close;
      logic [31:0] word;
      logic [30:0] length;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // One table step of the reflected CRC-32.
   function automatic logic [31:0] crc_table_entry(input logic [7:0] idx);
      logic [31:0] r;
      r = {24'd0, idx};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
      return crc_table_entry(crc[7:0] ^ b) ^ (crc >> 8);
   endfunction

endpackage

### rtl/core/pcf_front.sv
// Front end of the chunk framer: accepts items, tracks the open chunk,
// drops stray payload bytes and pushes commands. Depends on pcf_pkg.
module pcf_front import pcf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   input  q_status_type q_status,
   output logic         push,
   output cmd_type      push_cmd
);

   logic        open_ff, open_in;
   logic [30:0] left_ff, left_in;
   logic        accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   always_comb begin
      open_in  = open_ff;
      left_in  = left_ff;
      push     = 1'b0;
      push_cmd = '0;
      if (accept) begin
         if (req_item.kind == KIND_START) begin
            push            = 1'b1;
            push_cmd.is_data = 1'b0;
            push_cmd.close  = (req_item.chunk_length == '0);
            push_cmd.word   = req_item.chunk_type;
            push_cmd.length = req_item.chunk_length;
            open_in         = (req_item.chunk_length != '0);
            left_in         = req_item.chunk_length;
         end else if (open_ff) begin
            push             = 1'b1;
            push_cmd.is_data = 1'b1;
            push_cmd.close   = (left_ff == 31'd1);
            push_cmd.word    = {24'd0, req_item.data_byte};
            left_in          = left_ff - 31'd1;
            open_in          = (left_ff != 31'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         open_ff <= open_in;
         left_ff <= left_in;
      end
   end

   a_open_has_bytes: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> (left_ff != '0))
      else $error("open chunk with no bytes left");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("command pushed into full queue");

   a_stray_byte_dropped: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.kind == KIND_DATA && !open_ff) |=> (open_ff == 1'b0))
      else $error("stray payload byte opened a chunk");

endmodule

### rtl/core/pcf_queue.sv
// Small command FIFO between front and back ends, head read combinationally.
// Depends on pcf_pkg for the command and status types.
module pcf_queue import pcf_pkg::*; #(
   parameter int unsigned DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   input  logic         pop,
   output cmd_type      head,
   output q_status_type q_status
);

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   cmd_type         slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_pop;

   assign q_status.full  = (count_ff == CW'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head           = slot_ff[rd_ptr_ff];
   assign do_pop         = pop && !q_status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      case ({push, do_pop})
         2'b10:   count_in = CW'(count_ff + 1'b1);
         2'b01:   count_in = CW'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count out of range");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == CW'($past(count_ff) + 1'b1)))
      else $error("count did not follow push");

endmodule

### rtl/core/pcf_back.sv
// Back end of the chunk framer: walks each queued command byte by byte,
// folds the CRC and feeds the output register. Depends on pcf_pkg.
module pcf_back import pcf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      head,
   input  q_status_type q_status,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic              mid_ff, mid_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [31:0]       crc_ff, crc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;

   logic              advance;
   logic              work;
   logic [STEP_W-1:0] cur_step;
   logic [STEP_W-1:0] last_step;
   logic [31:0]       len_word;
   logic [31:0]       crc_out;
   logic [31:0]       crc_base;
   logic [7:0]        cur_byte;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign work      = advance && !q_status.empty;
   assign cur_step  = mid_ff ? step_ff : (head.is_data ? STEP_BYTE_LAST : STEP_LEN_FIRST);
   assign last_step = head.close ? STEP_CRC_LAST : STEP_BYTE_LAST;
   assign len_word  = {1'b0, head.length};
   assign crc_out   = crc_ff ^ CRC_ALL_ONES;
   // The type walk restarts from all ones, which also drops an abandoned chunk.
   assign crc_base  = (!head.is_data && cur_step == STEP_TYPE_FIRST) ? CRC_ALL_ONES : crc_ff;

   always_comb begin
      case (cur_step)
         4'd0:    cur_byte = len_word[31:24];
         4'd1:    cur_byte = len_word[23:16];
         4'd2:    cur_byte = len_word[15:8];
         4'd3:    cur_byte = len_word[7:0];
         4'd4:    cur_byte = head.word[31:24];
         4'd5:    cur_byte = head.word[23:16];
         4'd6:    cur_byte = head.word[15:8];
         4'd7:    cur_byte = head.word[7:0];
         4'd8:    cur_byte = crc_out[31:24];
         4'd9:    cur_byte = crc_out[23:16];
         4'd10:   cur_byte = crc_out[15:8];
         4'd11:   cur_byte = crc_out[7:0];
         default: cur_byte = '0;
      endcase
   end

   always_comb begin
      mid_in       = mid_ff;
      step_in      = step_ff;
      crc_in       = crc_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (advance) begin
         rsp_valid_in = work;
      end
      if (work) begin
         rsp_item_in.out_byte  = cur_byte;
         rsp_item_in.run_end   = (cur_step == last_step);
         rsp_item_in.chunk_end = (cur_step == STEP_CRC_LAST);
         if (cur_step >= STEP_TYPE_FIRST && cur_step <= STEP_BYTE_LAST) begin
            crc_in = crc_fold(crc_base, cur_byte);
         end
         if (cur_step == last_step) begin
            pop    = 1'b1;
            mid_in = 1'b0;
         end else begin
            mid_in  = 1'b1;
            step_in = STEP_W'(cur_step + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff       <= 1'b0;
         step_ff      <= '0;
         crc_ff       <= CRC_ALL_ONES;
         rsp_valid_ff <= 1'b0;
      end else begin
         mid_ff       <= mid_in;
         step_ff      <= step_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_mid_has_head: assert property (@(posedge clock) disable iff (reset)
      mid_ff |-> !q_status.empty)
      else $error("command in progress but queue empty");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      mid_ff |-> (step_ff <= STEP_CRC_LAST))
      else $error("step beyond CRC tail");

   a_chunk_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.chunk_end) |-> rsp_item_ff.run_end)
      else $error("chunk end without run end");

   a_crc_holds_in_tail: assert property (@(posedge clock) disable iff (reset)
      (mid_ff && step_ff > STEP_BYTE_LAST) |=> $stable(crc_ff))
      else $error("CRC changed while its bytes go out");

endmodule

### rtl/core/png_chunk_framer_crc32.sv
// Top level of the PNG chunk framer with CRC-32.
// Depends on pcf_pkg, pcf_front, pcf_queue and pcf_back.
//
//   channel | ports                          | moves
//   --------+--------------------------------+----------------------------------
//   request | req_valid, req_stall, req_item | start (type, length) or one byte
//   result  | rsp_valid, rsp_stall, rsp_item | one framed byte plus end flags
//
// Output: a payload byte yields one framed byte, the last one also the CRC;
//   a start item yields length and type bytes, and the CRC for an empty chunk.
//   The back end's single byte emitter sends one byte per cycle while the result
//   side does not stall, with one table step of the CRC per type or payload byte.
// Reset: synchronous, clears the queue, the open-chunk state and rsp_valid.
// Stalls: the command queue lets the front keep accepting while the back end
//   or the result side waits; req_stall rises only when the queue is full.
module png_chunk_framer_crc32 import pcf_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 4   // commands buffered, 2 or more
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   // front -> queue
   logic         push;
   cmd_type      push_cmd;
   // queue -> front/back
   q_status_type q_status;
   cmd_type      head;
   // back -> queue
   logic         pop;

   // Front: classifies items, keeps the open-chunk flag and the byte countdown,
   // drops payload bytes that arrive with no open chunk.
   pcf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .q_status  (q_status),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   pcf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   // Back: length, type, payload and CRC bytes into the output register, one per
   // cycle unless rsp_stall holds; the head command is popped with its last byte.
   pcf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

### tb/sv/tb_png_chunk_framer_crc32.sv
// Self-checking testbench for png_chunk_framer_crc32: drives start and payload
// items, predicts the framed byte stream with its own CRC-32 and checks it.
// Depends on pcf_pkg and the framer RTL.
module tb_png_chunk_framer_crc32;
   import pcf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Scoreboard: owns a private copy of the framer state and a queue of
   // framed bytes still owed by the block.
   class chunk_scoreboard;
      bit [31:0]    crc_rom [256];
      bit [31:0]    crc_acc;
      bit [30:0]    payload_left;
      bit           in_chunk;
      rsp_item_type framed_q [$];
      int unsigned  errors;
      int unsigned  bytes_checked;
      int unsigned  chunks_closed;
      int unsigned  chunks_dropped;
      int unsigned  strays;

      function new();
         bit [31:0] r;
         for (int i = 0; i < 256; i++) begin
            r = i;
            repeat (8) r = r[0] ? (32'hEDB8_8320 ^ (r >> 1)) : (r >> 1);
            crc_rom[i] = r;
         end
         crc_acc      = '1;
         payload_left = '0;
         in_chunk     = 1'b0;
      endfunction

      function void fold(bit [7:0] b);
         crc_acc = crc_rom[crc_acc[7:0] ^ b] ^ (crc_acc >> 8);
      endfunction

      function void push_byte(bit [7:0] b, bit last_of_chunk);
         rsp_item_type r;
         r.out_byte  = b;
         r.run_end   = 1'b0;
         r.chunk_end = last_of_chunk;
         framed_q.push_back(r);
      endfunction

      // Trailer: inverted CRC, big-endian, then the chunk is closed.
      function void push_crc();
         bit [31:0] c;
         c = ~crc_acc;
         push_byte(c[31:24], 1'b0);
         push_byte(c[23:16], 1'b0);
         push_byte(c[15:8],  1'b0);
         push_byte(c[7:0],   1'b1);
         in_chunk     = 1'b0;
         payload_left = '0;
         crc_acc      = '1;
         chunks_closed++;
      endfunction

      // Notes one accepted item; returns how many framed bytes it owes.
      function int note_request(req_item_type it);
         int        before_n;
         bit [31:0] len32;
         before_n = framed_q.size();
         if (it.kind == KIND_START) begin
            if (in_chunk) chunks_dropped++;
            len32 = {1'b0, it.chunk_length};
            for (int k = 3; k >= 0; k--) push_byte(len32[8*k +: 8], 1'b0);
            crc_acc = '1;
            for (int k = 3; k >= 0; k--) begin
               push_byte(it.chunk_type[8*k +: 8], 1'b0);
               fold(it.chunk_type[8*k +: 8]);
            end
            if (it.chunk_length == '0) begin
               push_crc();
            end else begin
               payload_left = it.chunk_length;
               in_chunk     = 1'b1;
            end
         end else if (!in_chunk) begin
            strays++;
         end else begin
            push_byte(it.data_byte, 1'b0);
            fold(it.data_byte);
            payload_left = payload_left - 1'b1;
            if (payload_left == '0) push_crc();
         end
         if (framed_q.size() > before_n) framed_q[framed_q.size() - 1].run_end = 1'b1;
         return framed_q.size() - before_n;
      endfunction

      function int pending();
         return framed_q.size();
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("[%0t] MISMATCH: %s", $realtime, what);
      endtask

      task check_result(rsp_item_type got);
         rsp_item_type want;
         if (framed_q.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h", got.out_byte));
         end else begin
            want = framed_q.pop_front();
            bytes_checked++;
            if (got.out_byte != want.out_byte)
               report_mismatch($sformatf("out_byte %02h, want %02h",
                                         got.out_byte, want.out_byte));
            if (got.run_end != want.run_end)
               report_mismatch($sformatf("run_end %0b, want %0b (byte %02h)",
                                         got.run_end, want.run_end, want.out_byte));
            if (got.chunk_end != want.chunk_end)
               report_mismatch($sformatf("chunk_end %0b, want %0b (byte %02h)",
                                         got.chunk_end, want.chunk_end, want.out_byte));
         end
      endtask
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   chunk_scoreboard sb = new();

   // Idle odds in percent, changed between phases by the main sequence.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned random_items  = 0;

   png_chunk_framer_crc32 i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: far beyond the slowest legal run, even with both sides idling
   // about half the time.
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Result side: random stall set at the falling edge, results taken at
   // the rising edge when valid and not stalled.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_item);
   end

   // Unused fields carry random bits; the block must ignore them.
   function automatic req_item_type start_item(logic [31:0] ctype, logic [30:0] len);
      req_item_type it;
      it.kind         = KIND_START;
      it.chunk_type   = ctype;
      it.chunk_length = len;
      it.data_byte    = 8'($urandom);
      return it;
   endfunction

   function automatic req_item_type data_item(logic [7:0] b);
      req_item_type it;
      it.kind         = KIND_DATA;
      it.chunk_type   = $urandom;
      it.chunk_length = 31'($urandom);
      it.data_byte    = b;
      return it;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   // n tells how many framed bytes the item owes (0 for a stray byte).
   task automatic send_item(input req_item_type it, output int n);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      n = sb.note_request(it);
      @(negedge clock);
   endtask

   task automatic send_start(logic [31:0] ctype, logic [30:0] len);
      int n;
      send_item(start_item(ctype, len), n);
      if (n > 0) random_items++;
   endtask

   task automatic send_byte(logic [7:0] b);
      int n;
      send_item(data_item(b), n);
      if (n > 0) random_items++;
   endtask

   // Extremes and corner cases: stray bytes, empty chunks, the longest length,
   // abandoned chunks, all-zero and all-one fields.
   task automatic run_directed();
      send_byte(8'hFF);                       // no chunk open: dropped
      send_start(32'h4945_4E44, 31'd0);       // empty IEND chunk
      send_start(32'hFFFF_FFFF, 31'd0);
      send_start(32'h0000_0000, 31'd1);
      send_byte(8'h00);
      send_start(32'h4948_4452, 31'd3);       // IHDR-like, three bytes
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'hA5);
      send_start(32'h4944_4154, 31'h7FFF_FFFF); // longest length
      send_byte(8'h5A);
      send_start(32'h7445_5874, 31'd2);       // abandons the long chunk
      send_byte(8'h80);
      send_byte(8'h01);
      send_byte(8'h33);                       // after close: dropped
      send_start(32'h1234_5678, 31'h5555_5555);
      send_start(32'h8765_4321, 31'h2AAA_AAAA); // abandons again
      send_start(32'hA5A5_A5A5, 31'd0);       // empty chunk also abandons
   endtask

   // Mostly well-formed chunks with short payloads; some starts with a
   // full-width length that get cut off, and some stray bytes.
   task automatic run_random(int unsigned quota);
      int unsigned goal;
      int unsigned pick;
      int unsigned len;
      goal = random_items + quota;
      while (random_items < goal) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12);
            send_start($urandom, 31'(len));
            repeat (len) send_byte(8'($urandom));
         end else if (pick < 85) begin
            send_start($urandom, 31'($urandom));
            repeat ($urandom_range(4)) send_byte(8'($urandom));
         end else begin
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
         end
      end
   endtask

   initial begin
      // Reset is held from time zero and released at a falling edge.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase 1: sender idles 37%, receiver stalls 49%.
      send_idle_pct = 37;
      recv_idle_pct = 49;
      run_directed();
      random_items = 0;
      run_random(122);

      // Phase 2: the other way round.
      send_idle_pct = 49;
      recv_idle_pct = 37;
      run_random(122);

      // Phase 3: full rate on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(120);
      req_valid <= 1'b0;

      // Drain, then watch a while for stray output.
      while (sb.pending() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Checked %0d framed bytes: %0d chunks closed, %0d abandoned, %0d stray bytes.",
               sb.bytes_checked, sb.chunks_closed, sb.chunks_dropped, sb.strays);
      $display("Three idle profiles: sender-heavy, receiver-heavy and none.");
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/pcf_pkg.sv
rtl/core/pcf_front.sv
rtl/core/pcf_queue.sv
rtl/core/pcf_back.sv
rtl/core/png_chunk_framer_crc32.sv
tb/sv/tb_png_chunk_framer_crc32.sv
